// ===== rtl/cpt_pkg.sv =====
// Package for the closest-point-on-triangle block: widths, region codes and
// the pipeline structures; side_t is shared between the top level and the divider.
// No dependencies.
package cpt_pkg;

  // Coordinate format.
  localparam int CW   = 24;            // coordinate width
  localparam int FW   = 12;            // fraction bits

  // Derived arithmetic widths; every intermediate result is exact.
  localparam int DW   = CW + 1;        // vertex and point differences
  localparam int PW   = 2 * DW;        // one coordinate product
  localparam int DOTW = PW + 2;        // dot products d1 to d6
  localparam int DXW  = DOTW + 1;      // differences of dot products
  localparam int DH   = DOTW / 2;      // low half of a split dot product
  localparam int DHH  = DOTW - DH;     // high half of a split dot product
  localparam int VW   = 2 * DOTW;      // va, vb, vc and their sum
  localparam int NW   = VW + FW;       // scaled numerator magnitude
  localparam int REMW = VW + 1;        // divider partial remainder
  localparam int QW   = NW + 1;        // signed quotient
  localparam int QN   = 4;             // chunks of a quotient in the final products
  localparam int QC   = (QW + QN - 1) / QN;
  localparam int QXW  = QN * QC;       // quotient widened to whole chunks
  localparam int PPW  = DW + QC + 1;   // one partial product of direction by quotient
  localparam int TW   = DW + QXW;      // one direction-by-quotient term
  localparam int SW   = TW + 1;        // sum of both terms
  localparam int RW   = SW + 1;        // base plus scaled sum, before saturation

  // Voronoi region reported with every result.
  typedef enum logic [2:0] {
    RG_A,
    RG_B,
    RG_C,
    RG_AB,
    RG_AC,
    RG_BC,
    RG_IN
  } region_t;

  // Triangle geometry carried down the front of the pipeline.
  typedef struct packed {
    logic [2:0][CW-1:0] a;
    logic [2:0][CW-1:0] b;
    logic [2:0][CW-1:0] c;
    logic [2:0][DW-1:0] ab;
    logic [2:0][DW-1:0] ac;
    logic [2:0][DW-1:0] bc;
  } geo_t;

  // What the back end needs alongside the quotients.
  typedef struct packed {
    region_t            region;
    logic               vert;
    logic [2:0][CW-1:0] base;
    logic [2:0][DW-1:0] dir1;
    logic [2:0][DW-1:0] dir2;
  } side_t;

endpackage

// ===== rtl/cpt_in_if.sv =====
// Query channel of the closest-point block: valid, ready and one query.
// Depends on cpt_pkg for the coordinate width.
interface cpt_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [cpt_pkg::CW-1:0]   point_x;
  logic signed [cpt_pkg::CW-1:0]   point_y;
  logic signed [cpt_pkg::CW-1:0]   point_z;
  logic signed [cpt_pkg::CW-1:0]   vert_a_x;
  logic signed [cpt_pkg::CW-1:0]   vert_a_y;
  logic signed [cpt_pkg::CW-1:0]   vert_a_z;
  logic signed [cpt_pkg::CW-1:0]   vert_b_x;
  logic signed [cpt_pkg::CW-1:0]   vert_b_y;
  logic signed [cpt_pkg::CW-1:0]   vert_b_z;
  logic signed [cpt_pkg::CW-1:0]   vert_c_x;
  logic signed [cpt_pkg::CW-1:0]   vert_c_y;
  logic signed [cpt_pkg::CW-1:0]   vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

// ===== rtl/cpt_out_if.sv =====
// Result channel of the closest-point block: valid, ready, nearest point
// and region. Depends on cpt_pkg for the coordinate width.
interface cpt_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [cpt_pkg::CW-1:0]   near_x;
  logic signed [cpt_pkg::CW-1:0]   near_y;
  logic signed [cpt_pkg::CW-1:0]   near_z;
  logic [2:0]                      region;

  modport source (
    output valid, near_x, near_y, near_z, region,
    input  ready
  );

  modport sink (
    input  valid, near_x, near_y, near_z, region,
    output ready
  );
endinterface

// ===== rtl/cpt_divider.sv =====
// Pipelined restoring divider with two lanes sharing one divisor; one
// quotient bit per stage. Depends on cpt_pkg.
module cpt_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [cpt_pkg::NW-1:0]        num_v,
  input  logic [cpt_pkg::NW-1:0]        num_w,
  input  logic [cpt_pkg::VW-1:0]        den,
  input  logic                          neg_v,
  input  logic                          neg_w,
  input  logic                          den_zero,
  input  cpt_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic signed [cpt_pkg::QW-1:0] q_v,
  output logic signed [cpt_pkg::QW-1:0] q_w,
  output cpt_pkg::side_t                out_side
);
  import cpt_pkg::*;

  typedef struct packed {
    logic [REMW-1:0] rem_v;
    logic [REMW-1:0] rem_w;
    logic [NW-1:0]   nq_v;
    logic [NW-1:0]   nq_w;
    logic [VW-1:0]   den;
    logic            neg_v;
    logic            neg_w;
    logic            zero;
    side_t           side;
  } stage_t;

  // One restoring step: the numerator shifts out at the top while the
  // quotient bit shifts in at the bottom of the same register.
  function automatic logic [REMW+NW-1:0] div_step(input logic [REMW-1:0] rem,
                                                  input logic [NW-1:0]   nq,
                                                  input logic [VW-1:0]   d);
    logic [REMW-1:0] sh;
    logic [REMW-1:0] diff;
    logic            ge;
    sh   = {rem[REMW-2:0], nq[NW-1]};
    diff = sh - {1'b0, d};
    ge   = (sh >= {1'b0, d});
    return {(ge ? diff : sh), nq[NW-2:0], ge};
  endfunction

  stage_t        head;
  stage_t        st_r [NW];
  logic [NW-1:0] vld_r;

  // Entry into the first stage.
  always_comb begin
    head       = '0;
    head.nq_v  = num_v;
    head.nq_w  = num_w;
    head.den   = den;
    head.neg_v = neg_v;
    head.neg_w = neg_w;
    head.zero  = den_zero;
    head.side  = in_side;
  end

  for (genvar i = 0; i < NW; i++) begin : g_stage
    stage_t src;
    stage_t st_nxt;
    logic   src_vld;

    if (i == 0) begin : g_first
      assign src     = head;
      assign src_vld = in_valid;
    end else begin : g_next
      assign src     = st_r[i-1];
      assign src_vld = vld_r[i-1];
    end

    // One quotient bit for each lane.
    always_comb begin
      st_nxt = src;
      {st_nxt.rem_v, st_nxt.nq_v} = div_step(src.rem_v, src.nq_v, src.den);
      {st_nxt.rem_w, st_nxt.nq_w} = div_step(src.rem_w, src.nq_w, src.den);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i] <= st_nxt;
      end
    end
  end

  // Apply signs; a zero divisor gives a zero quotient.
  always_comb begin
    if (st_r[NW-1].zero) begin
      q_v = '0;
      q_w = '0;
    end else begin
      q_v = st_r[NW-1].neg_v ? -$signed({1'b0, st_r[NW-1].nq_v})
                             : $signed({1'b0, st_r[NW-1].nq_v});
      q_w = st_r[NW-1].neg_w ? -$signed({1'b0, st_r[NW-1].nq_w})
                             : $signed({1'b0, st_r[NW-1].nq_w});
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_side  = st_r[NW-1].side;

endmodule

// ===== rtl/closest_point_on_triangle.sv =====
// Closest point on a triangle: pipelined top level.
// Depends on cpt_pkg, cpt_in_if, cpt_out_if and cpt_divider.
//
// Usage:
//   in_ch carries one query per transfer: point P and vertices A, B and C,
//   each coordinate signed Q12.12. out_ch returns one result per query, in
//   order: the nearest point of the triangle and the Voronoi region chosen.
//   The pipeline is 129 registers deep. A new query is taken in every cycle
//   unless the pipeline holds; the rate is one item per cycle while the
//   receiver keeps up, and the depth is set by the divider, which makes one
//   quotient bit per stage over 116 stages, shared by both interior quotients.
//   All stages advance together. When the receiver holds ready low with a
//   result waiting, the whole pipeline holds and in_ch.ready drops; no item
//   is lost or repeated. While the result register is empty, ready stays
//   high even if the receiver stalls.
//   Reset clears all valid bits; the pipeline needs no further start-up.
module closest_point_on_triangle (
  input  logic      clk,
  input  logic      rst_n,
  cpt_in_if.sink    in_ch,
  cpt_out_if.source out_ch
);
  import cpt_pkg::*;

  // Operands of the six cross products d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
  localparam int XL [6] = '{0, 2, 4, 0, 2, 4};
  localparam int XR [6] = '{3, 1, 1, 5, 5, 3};

  function automatic logic le0_dot(input logic [DOTW-1:0] x);
    return x[DOTW-1] || (x == '0);
  endfunction

  function automatic logic le0_dx(input logic [DXW-1:0] x);
    return x[DXW-1] || (x == '0);
  endfunction

  function automatic logic le0_w(input logic [VW-1:0] x);
    return x[VW-1] || (x == '0);
  endfunction

  logic en;
  logic out_valid_r;

  // The pipeline moves whenever the result register is free or being taken.
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------------------------------------------------------------
  // Stage 1: differences.
  logic [2:0][CW-1:0] in_p, in_a, in_b, in_c;
  logic               s1_valid_r;
  geo_t               s1_geo_r, s1_geo_nxt;
  logic [2:0][DW-1:0] s1_ap_r, s1_bp_r, s1_cp_r;
  logic [2:0][DW-1:0] s1_ap_nxt, s1_bp_nxt, s1_cp_nxt;

  assign in_p = {in_ch.point_z, in_ch.point_y, in_ch.point_x};
  assign in_a = {in_ch.vert_a_z, in_ch.vert_a_y, in_ch.vert_a_x};
  assign in_b = {in_ch.vert_b_z, in_ch.vert_b_y, in_ch.vert_b_x};
  assign in_c = {in_ch.vert_c_z, in_ch.vert_c_y, in_ch.vert_c_x};

  always_comb begin
    s1_geo_nxt.a = in_a;
    s1_geo_nxt.b = in_b;
    s1_geo_nxt.c = in_c;
    for (int k = 0; k < 3; k++) begin
      s1_geo_nxt.ab[k] = DW'($signed(in_b[k])) - DW'($signed(in_a[k]));
      s1_geo_nxt.ac[k] = DW'($signed(in_c[k])) - DW'($signed(in_a[k]));
      s1_geo_nxt.bc[k] = DW'($signed(in_c[k])) - DW'($signed(in_b[k]));
      s1_ap_nxt[k]     = DW'($signed(in_p[k])) - DW'($signed(in_a[k]));
      s1_bp_nxt[k]     = DW'($signed(in_p[k])) - DW'($signed(in_b[k]));
      s1_cp_nxt[k]     = DW'($signed(in_p[k])) - DW'($signed(in_c[k]));
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: the eighteen coordinate products of the six dot products.
  logic                 s2_valid_r;
  geo_t                 s2_geo_r;
  logic signed [PW-1:0] s2_prod_r   [6][3];
  logic signed [PW-1:0] s2_prod_nxt [6][3];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (j % 2 == 0) begin
          s2_prod_nxt[j][k] = $signed(s1_geo_r.ab[k]) *
                              $signed((j / 2 == 0) ? s1_ap_r[k] :
                                      (j / 2 == 1) ? s1_bp_r[k] : s1_cp_r[k]);
        end else begin
          s2_prod_nxt[j][k] = $signed(s1_geo_r.ac[k]) *
                              $signed((j / 2 == 0) ? s1_ap_r[k] :
                                      (j / 2 == 1) ? s1_bp_r[k] : s1_cp_r[k]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: dot products d1 to d6.
  logic                   s3_valid_r;
  geo_t                   s3_geo_r;
  logic signed [DOTW-1:0] s3_d_r   [6];
  logic signed [DOTW-1:0] s3_d_nxt [6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      s3_d_nxt[j] = DOTW'(s2_prod_r[j][0]) + DOTW'(s2_prod_r[j][1]) +
                    DOTW'(s2_prod_r[j][2]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: cross products split into half-width partial products.
  logic                      s4_valid_r;
  geo_t                      s4_geo_r;
  logic signed [DOTW-1:0]    s4_d_r [6];
  logic signed [2*DHH-1:0]   s4_hh_r [6], s4_hh_nxt [6];
  logic signed [DHH+DH:0]    s4_hl_r [6], s4_hl_nxt [6];
  logic signed [DHH+DH:0]    s4_lh_r [6], s4_lh_nxt [6];
  logic [2*DH-1:0]           s4_ll_r [6], s4_ll_nxt [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      s4_hh_nxt[i] = $signed(s3_d_r[XL[i]][DOTW-1:DH]) *
                     $signed(s3_d_r[XR[i]][DOTW-1:DH]);
      s4_hl_nxt[i] = $signed(s3_d_r[XL[i]][DOTW-1:DH]) *
                     $signed({1'b0, s3_d_r[XR[i]][DH-1:0]});
      s4_lh_nxt[i] = $signed({1'b0, s3_d_r[XL[i]][DH-1:0]}) *
                     $signed(s3_d_r[XR[i]][DOTW-1:DH]);
      s4_ll_nxt[i] = s3_d_r[XL[i]][DH-1:0] * s3_d_r[XR[i]][DH-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: cross products reassembled.
  logic                   s5_valid_r;
  geo_t                   s5_geo_r;
  logic signed [DOTW-1:0] s5_d_r [6];
  logic signed [VW-1:0]   s5_x_r [6], s5_x_nxt [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      s5_x_nxt[i] = (VW'(s4_hh_r[i]) <<< (2 * DH)) + (VW'(s4_hl_r[i]) <<< DH) +
                    (VW'(s4_lh_r[i]) <<< DH) + VW'(s4_ll_r[i]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: barycentric numerators va, vb, vc.
  logic                   s6_valid_r;
  geo_t                   s6_geo_r;
  logic signed [DOTW-1:0] s6_d_r [6];
  logic signed [VW-1:0]   s6_va_r, s6_vb_r, s6_vc_r;

  // ---------------------------------------------------------------------
  // Stage 7: region choice in priority order and the interior denominator.
  logic                   s7_valid_r;
  geo_t                   s7_geo_r;
  logic signed [DOTW-1:0] s7_d_r [6];
  logic signed [VW-1:0]   s7_vb_r, s7_vc_r;
  logic signed [VW-1:0]   s7_den_r, s7_den_nxt;
  logic signed [DXW-1:0]  s7_d43_r, s7_d43_nxt, s7_d56_r, s7_d56_nxt;
  region_t                s7_region_r, s7_region_nxt;

  always_comb begin
    s7_d43_nxt = DXW'(s6_d_r[3]) - DXW'(s6_d_r[2]);
    s7_d56_nxt = DXW'(s6_d_r[4]) - DXW'(s6_d_r[5]);
    s7_den_nxt = s6_va_r + s6_vb_r + s6_vc_r;
    if (le0_dot(s6_d_r[0]) && le0_dot(s6_d_r[1])) begin
      s7_region_nxt = RG_A;
    end else if (!s6_d_r[2][DOTW-1] && le0_dx(s7_d43_nxt)) begin
      s7_region_nxt = RG_B;
    end else if (!s6_d_r[5][DOTW-1] && le0_dx(s7_d56_nxt)) begin
      s7_region_nxt = RG_C;
    end else if (le0_w(s6_vc_r) && !s6_d_r[0][DOTW-1] && le0_dot(s6_d_r[2])) begin
      s7_region_nxt = RG_AB;
    end else if (le0_w(s6_vb_r) && !s6_d_r[1][DOTW-1] && le0_dot(s6_d_r[5])) begin
      s7_region_nxt = RG_AC;
    end else if (le0_w(s6_va_r) && !s7_d43_nxt[DXW-1] && !s7_d56_nxt[DXW-1]) begin
      s7_region_nxt = RG_BC;
    end else begin
      s7_region_nxt = RG_IN;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: quotient operands as magnitudes and signs; base and directions.
  logic                 s8_valid_r;
  logic [NW-1:0]        s8_num_v_r, s8_num_w_r, s8_num_v_nxt, s8_num_w_nxt;
  logic [VW-1:0]        s8_den_r, s8_den_nxt;
  logic                 s8_neg_v_r, s8_neg_w_r, s8_zero_r;
  logic                 s8_neg_v_nxt, s8_neg_w_nxt, s8_zero_nxt;
  side_t                s8_side_r, s8_side_nxt;
  logic signed [VW-1:0] sel_n1, sel_n2, sel_den;
  logic [VW-1:0]        mag_n1, mag_n2;

  always_comb begin
    sel_n1 = '0;
    sel_n2 = '0;
    sel_den = '0;
    s8_side_nxt.region = s7_region_r;
    s8_side_nxt.vert   = 1'b0;
    s8_side_nxt.base   = s7_geo_r.a;
    s8_side_nxt.dir1   = s7_geo_r.ab;
    s8_side_nxt.dir2   = s7_geo_r.ac;
    case (s7_region_r)
      RG_A: begin
        s8_side_nxt.vert = 1'b1;
      end
      RG_B: begin
        s8_side_nxt.vert = 1'b1;
        s8_side_nxt.base = s7_geo_r.b;
      end
      RG_C: begin
        s8_side_nxt.vert = 1'b1;
        s8_side_nxt.base = s7_geo_r.c;
      end
      RG_AB: begin
        sel_n1  = VW'(s7_d_r[0]);
        sel_den = VW'(s7_d_r[0]) - VW'(s7_d_r[2]);
      end
      RG_AC: begin
        sel_n1  = VW'(s7_d_r[1]);
        sel_den = VW'(s7_d_r[1]) - VW'(s7_d_r[5]);
        s8_side_nxt.dir1 = s7_geo_r.ac;
      end
      RG_BC: begin
        sel_n1  = VW'(s7_d43_r);
        sel_den = VW'(s7_d43_r) + VW'(s7_d56_r);
        s8_side_nxt.base = s7_geo_r.b;
        s8_side_nxt.dir1 = s7_geo_r.bc;
      end
      RG_IN: begin
        sel_n1  = s7_vb_r;
        sel_n2  = s7_vc_r;
        sel_den = s7_den_r;
      end
      default: begin
        s8_side_nxt.vert = 1'b1;
      end
    endcase
    mag_n1       = sel_n1[VW-1] ? -sel_n1 : sel_n1;
    mag_n2       = sel_n2[VW-1] ? -sel_n2 : sel_n2;
    s8_den_nxt   = sel_den[VW-1] ? -sel_den : sel_den;
    s8_num_v_nxt = {mag_n1, {FW{1'b0}}};
    s8_num_w_nxt = {mag_n2, {FW{1'b0}}};
    s8_neg_v_nxt = sel_n1[VW-1] ^ sel_den[VW-1];
    s8_neg_w_nxt = sel_n2[VW-1] ^ sel_den[VW-1];
    s8_zero_nxt  = (sel_den == '0);
  end

  // ---------------------------------------------------------------------
  // Divider: both quotients, truncated toward zero.
  logic                 dv_valid;
  logic signed [QW-1:0] dv_q_v, dv_q_w;
  side_t                dv_side;

  cpt_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s8_valid_r),
    .num_v     (s8_num_v_r),
    .num_w     (s8_num_w_r),
    .den       (s8_den_r),
    .neg_v     (s8_neg_v_r),
    .neg_w     (s8_neg_w_r),
    .den_zero  (s8_zero_r),
    .in_side   (s8_side_r),
    .out_valid (dv_valid),
    .q_v       (dv_q_v),
    .q_w       (dv_q_w),
    .out_side  (dv_side)
  );

  // ---------------------------------------------------------------------
  // Quotient register, then direction times quotient in chunks.
  logic                 sq_valid_r;
  logic signed [QW-1:0] sq_q_v_r, sq_q_w_r;
  side_t                sq_side_r;

  logic                  m1_valid_r;
  side_t                 m1_side_r;
  logic signed [PPW-1:0] m1_pp_r   [3][2][QN];
  logic signed [PPW-1:0] m1_pp_nxt [3][2][QN];
  logic [QXW-1:0]        qx [2];

  always_comb begin
    qx[0] = QXW'(sq_q_v_r);
    qx[1] = QXW'(sq_q_w_r);
    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t < 2; t++) begin
        for (int c = 0; c < QN; c++) begin
          if (c == QN - 1) begin
            m1_pp_nxt[k][t][c] = $signed(t == 0 ? sq_side_r.dir1[k] : sq_side_r.dir2[k]) *
                                 $signed(qx[t][c*QC +: QC]);
          end else begin
            m1_pp_nxt[k][t][c] = $signed(t == 0 ? sq_side_r.dir1[k] : sq_side_r.dir2[k]) *
                                 $signed({1'b0, qx[t][c*QC +: QC]});
          end
        end
      end
    end
  end

  // Terms reassembled from their chunks.
  logic                 m2_valid_r;
  side_t                m2_side_r;
  logic signed [TW-1:0] m2_term_r   [3][2];
  logic signed [TW-1:0] m2_term_nxt [3][2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t < 2; t++) begin
        m2_term_nxt[k][t] = '0;
        for (int c = 0; c < QN; c++) begin
          m2_term_nxt[k][t] = m2_term_nxt[k][t] + (TW'(m1_pp_r[k][t][c]) <<< (c * QC));
        end
      end
    end
  end

  // Sum of terms, scaled back by the fraction bits, plus the base vertex.
  logic                 m3_valid_r;
  side_t                m3_side_r;
  logic signed [RW-1:0] m3_res_r   [3];
  logic signed [RW-1:0] m3_res_nxt [3];
  logic signed [SW-1:0] m3_sum     [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m3_sum[k]     = SW'(m2_term_r[k][0]) + SW'(m2_term_r[k][1]);
      m3_res_nxt[k] = RW'(m3_sum[k] >>> FW) + RW'($signed(m2_side_r.base[k]));
    end
  end

  // Result register: vertex pass-through or saturated coordinate.
  logic [2:0][CW-1:0] out_near_r, out_near_nxt;
  region_t            out_region_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (m3_side_r.vert) begin
        out_near_nxt[k] = m3_side_r.base[k];
      end else if ((m3_res_r[k][RW-1:CW-1] == '0) || (m3_res_r[k][RW-1:CW-1] == '1)) begin
        out_near_nxt[k] = m3_res_r[k][CW-1:0];
      end else if (m3_res_r[k][RW-1]) begin
        out_near_nxt[k] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        out_near_nxt[k] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.near_x = out_near_r[0];
  assign out_ch.near_y = out_near_r[1];
  assign out_ch.near_z = out_near_r[2];
  assign out_ch.region = out_region_r;

  // ---------------------------------------------------------------------
  // Valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      s7_valid_r  <= 1'b0;
      s8_valid_r  <= 1'b0;
      sq_valid_r  <= 1'b0;
      m1_valid_r  <= 1'b0;
      m2_valid_r  <= 1'b0;
      m3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_ch.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      s7_valid_r  <= s6_valid_r;
      s8_valid_r  <= s7_valid_r;
      sq_valid_r  <= dv_valid;
      m1_valid_r  <= sq_valid_r;
      m2_valid_r  <= m1_valid_r;
      m3_valid_r  <= m2_valid_r;
      out_valid_r <= m3_valid_r;
    end
  end

  // Payload registers; they move with the valid bits and need no reset.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_geo_r     <= s1_geo_nxt;
      s1_ap_r      <= s1_ap_nxt;
      s1_bp_r      <= s1_bp_nxt;
      s1_cp_r      <= s1_cp_nxt;
      s2_geo_r     <= s1_geo_r;
      s2_prod_r    <= s2_prod_nxt;
      s3_geo_r     <= s2_geo_r;
      s3_d_r       <= s3_d_nxt;
      s4_geo_r     <= s3_geo_r;
      s4_d_r       <= s3_d_r;
      s4_hh_r      <= s4_hh_nxt;
      s4_hl_r      <= s4_hl_nxt;
      s4_lh_r      <= s4_lh_nxt;
      s4_ll_r      <= s4_ll_nxt;
      s5_geo_r     <= s4_geo_r;
      s5_d_r       <= s4_d_r;
      s5_x_r       <= s5_x_nxt;
      s6_geo_r     <= s5_geo_r;
      s6_d_r       <= s5_d_r;
      s6_vc_r      <= s5_x_r[0] - s5_x_r[1];
      s6_vb_r      <= s5_x_r[2] - s5_x_r[3];
      s6_va_r      <= s5_x_r[4] - s5_x_r[5];
      s7_geo_r     <= s6_geo_r;
      s7_d_r       <= s6_d_r;
      s7_vb_r      <= s6_vb_r;
      s7_vc_r      <= s6_vc_r;
      s7_den_r     <= s7_den_nxt;
      s7_d43_r     <= s7_d43_nxt;
      s7_d56_r     <= s7_d56_nxt;
      s7_region_r  <= s7_region_nxt;
      s8_num_v_r   <= s8_num_v_nxt;
      s8_num_w_r   <= s8_num_w_nxt;
      s8_den_r     <= s8_den_nxt;
      s8_neg_v_r   <= s8_neg_v_nxt;
      s8_neg_w_r   <= s8_neg_w_nxt;
      s8_zero_r    <= s8_zero_nxt;
      s8_side_r    <= s8_side_nxt;
      sq_q_v_r     <= dv_q_v;
      sq_q_w_r     <= dv_q_w;
      sq_side_r    <= dv_side;
      m1_side_r    <= sq_side_r;
      m1_pp_r      <= m1_pp_nxt;
      m2_side_r    <= m1_side_r;
      m2_term_r    <= m2_term_nxt;
      m3_side_r    <= m2_side_r;
      m3_res_r     <= m3_res_nxt;
      out_near_r   <= out_near_nxt;
      out_region_r <= m3_side_r.region;
    end
  end

  // ---------------------------------------------------------------------
  // Checks on the datapath.

  // A vertex region returns the vertex itself.
  a_vert_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (en && m3_valid_r && m3_side_r.vert) |=> (out_near_r == $past(m3_side_r.base)))
    else $error("vertex region result differs from the vertex");

  // Vertex regions carry no quotient.
  a_vert_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid && dv_side.vert) |-> (dv_q_v == '0 && dv_q_w == '0))
    else $error("vertex region produced a non-zero quotient");

  // Only the interior uses the second quotient.
  a_edge_w: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid && dv_side.region != RG_IN) |-> (dv_q_w == '0))
    else $error("second quotient non-zero outside the interior");

endmodule

// ===== verif/closest_point_on_triangle_checker.sv =====
// Checker for the closest-point-on-triangle block: predicts the nearest point
// and region for every query transfer and compares result transfers in order.
// Depends on cpt_pkg, cpt_in_if and cpt_out_if.
module closest_point_on_triangle_checker (
  input  logic  clk,
  input  logic  rst_n,
  cpt_in_if     in_ch,
  cpt_out_if    out_ch,
  output int    fail_count,
  output int    awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpt_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t  x;
    coord_t  y;
    coord_t  z;
    region_t region;
  } nearest_t;

  nearest_t awaited_q[$];

  // Exact dot product of two difference vectors.
  function automatic wide_t dot3(wide_t u[3], wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  // Quotient with FW fraction bits, truncated toward zero; zero when d is zero.
  function automatic wide_t ratio(wide_t n, wide_t d);
    if (d == 0) return '0;
    return (n <<< FW) / d;
  endfunction

  // Clamp to the signed coordinate range.
  function automatic coord_t clamp_coord(wide_t r);
    wide_t lo;
    wide_t hi;
    lo = -(wide_t'(1) <<< (CW - 1));
    hi = (wide_t'(1) <<< (CW - 1)) - 1;
    if (r < lo) return coord_t'(lo);
    if (r > hi) return coord_t'(hi);
    return coord_t'(r);
  endfunction

  // Nearest point of triangle abc to point p, with the Voronoi region.
  function automatic nearest_t nearest_point(coord_t p[3], coord_t a[3],
                                             coord_t b[3], coord_t c[3]);
    wide_t ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
    wide_t base[3], dir1[3], dir2[3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, v, w, s;
    coord_t res[3];
    logic vert;
    region_t rg;
    nearest_t n;
    for (int k = 0; k < 3; k++) begin
      ab[k] = wide_t'(b[k]) - wide_t'(a[k]);
      ac[k] = wide_t'(c[k]) - wide_t'(a[k]);
      bc[k] = wide_t'(c[k]) - wide_t'(b[k]);
      ap[k] = wide_t'(p[k]) - wide_t'(a[k]);
      bp[k] = wide_t'(p[k]) - wide_t'(b[k]);
      cp[k] = wide_t'(p[k]) - wide_t'(c[k]);
      base[k] = wide_t'(a[k]);
      dir1[k] = ab[k];
      dir2[k] = ac[k];
    end
    d1 = dot3(ab, ap); d2 = dot3(ac, ap);
    d3 = dot3(ab, bp); d4 = dot3(ac, bp);
    d5 = dot3(ab, cp); d6 = dot3(ac, cp);
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    v = '0;
    w = '0;
    vert = 1'b0;
    // Regions are tried in a fixed order; the first test that passes wins.
    if (d1 <= 0 && d2 <= 0) begin
      rg = RG_A; vert = 1'b1;
      for (int k = 0; k < 3; k++) base[k] = wide_t'(a[k]);
    end else if (d3 >= 0 && d4 - d3 <= 0) begin
      rg = RG_B; vert = 1'b1;
      for (int k = 0; k < 3; k++) base[k] = wide_t'(b[k]);
    end else if (d6 >= 0 && d5 - d6 <= 0) begin
      rg = RG_C; vert = 1'b1;
      for (int k = 0; k < 3; k++) base[k] = wide_t'(c[k]);
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      rg = RG_AB;
      v = ratio(d1, d1 - d3);
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      rg = RG_AC;
      for (int k = 0; k < 3; k++) dir1[k] = ac[k];
      v = ratio(d2, d2 - d6);
    end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
      rg = RG_BC;
      for (int k = 0; k < 3; k++) begin
        base[k] = wide_t'(b[k]);
        dir1[k] = bc[k];
      end
      v = ratio(d4 - d3, (d4 - d3) + (d5 - d6));
    end else begin
      rg = RG_IN;
      v = ratio(vb, va + vb + vc);
      w = ratio(vc, va + vb + vc);
    end
    for (int k = 0; k < 3; k++) begin
      if (vert) begin
        res[k] = coord_t'(base[k]);
      end else begin
        s = dir1[k] * v + dir2[k] * w;
        res[k] = clamp_coord(base[k] + (s >>> FW));
      end
    end
    n.x = res[0]; n.y = res[1]; n.z = res[2]; n.region = rg;
    return n;
  endfunction

  // Predict on each query transfer and compare each result transfer.
  always @(posedge clk) begin
    coord_t p[3], a[3], b[3], c[3];
    nearest_t exp_n;
    if (!rst_n) begin
      awaited_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        p = '{in_ch.point_x, in_ch.point_y, in_ch.point_z};
        a = '{in_ch.vert_a_x, in_ch.vert_a_y, in_ch.vert_a_z};
        b = '{in_ch.vert_b_x, in_ch.vert_b_y, in_ch.vert_b_z};
        c = '{in_ch.vert_c_x, in_ch.vert_c_y, in_ch.vert_c_z};
        awaited_q.push_back(nearest_point(p, a, b, c));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result transfer with nothing awaited: %0d %0d %0d region %0d",
                   $time, out_ch.near_x, out_ch.near_y, out_ch.near_z, out_ch.region);
          fail_count++;
        end else begin
          exp_n = awaited_q.pop_front();
          if (out_ch.near_x !== exp_n.x || out_ch.near_y !== exp_n.y ||
              out_ch.near_z !== exp_n.z || out_ch.region !== exp_n.region) begin
            $display("%0t: mismatch: expected %0d %0d %0d region %0d, got %0d %0d %0d region %0d",
                     $time, exp_n.x, exp_n.y, exp_n.z, exp_n.region,
                     out_ch.near_x, out_ch.near_y, out_ch.near_z, out_ch.region);
            fail_count++;
          end
        end
      end
    end
    awaited_count = awaited_q.size();
  end

  initial begin
    fail_count = 0;
    awaited_count = 0;
  end
endmodule

// ===== verif/closest_point_on_triangle_tb.sv =====
// Top of the closest-point-on-triangle testbench: clock, reset, query and
// receiver stimulus, and the verdict. Depends on cpt_pkg, both channel
// interfaces, the block and closest_point_on_triangle_checker.
module closest_point_on_triangle_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpt_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int LONG_HOLD    = 400;
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int CMIN = -(1 << (CW - 1));

  typedef logic signed [CW-1:0] coord_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   awaited_count;
  int   cycle_count;
  int   hold_request;   // receiver behaviour: 0 random, 1 ready unless a hold is running
  logic long_hold;

  cpt_in_if  in_ch();
  cpt_out_if out_ch();

  closest_point_on_triangle DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  closest_point_on_triangle_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("closest_point_on_triangle_tb: FAIL");
      $finish;
    end
  end

  // Mostly short gaps, occasionally long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Receiver: random stalls, a long hold when asked for, and calm stretches.
  // A request for a long hold cuts short any random gap in progress.
  always @(posedge clk) begin
    int   hold_left;
    logic long_seen;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      long_seen = 1'b0;
    end else begin
      if (!long_hold) long_seen = 1'b0;
      if (long_hold && !long_seen) begin
        long_seen = 1'b1;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= (hold_left == 0);
      end else if (hold_request == 1) begin
        out_ch.ready <= 1'b1;
      end else begin
        hold_left = gap_len();
        out_ch.ready <= (hold_left == 0);
      end
    end
  end

  function automatic coord_t clip(longint v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom());
  endfunction

  // Offer one query and hold it until the block takes it.
  task automatic send_query(coord_t q[12]);
    logic taken;
    in_ch.valid    <= 1'b1;
    in_ch.point_x  <= q[0];  in_ch.point_y  <= q[1];  in_ch.point_z  <= q[2];
    in_ch.vert_a_x <= q[3];  in_ch.vert_a_y <= q[4];  in_ch.vert_a_z <= q[5];
    in_ch.vert_b_x <= q[6];  in_ch.vert_b_y <= q[7];  in_ch.vert_b_z <= q[8];
    in_ch.vert_c_x <= q[9];  in_ch.vert_c_y <= q[10]; in_ch.vert_c_z <= q[11];
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Vertices around a centre at a random scale, point near or inside.
  task automatic shaped_query(output coord_t q[12]);
    longint ctr[3];
    longint vx[3][3];
    longint span;
    int wa, wb, wc, kind;
    span = longint'(1) << $urandom_range(21, 3);
    for (int k = 0; k < 3; k++) ctr[k] = longint'(any_coord()) / 2;
    for (int j = 0; j < 3; j++)
      for (int k = 0; k < 3; k++)
        vx[j][k] = ctr[k] + $signed($urandom_range(2 * span)) - span;
    kind = $urandom_range(9);
    // Degenerate shapes: collapsed edges, a single point, collinear vertices.
    if (kind == 0) begin
      for (int k = 0; k < 3; k++) vx[1][k] = vx[0][k];
    end else if (kind == 1) begin
      for (int k = 0; k < 3; k++) begin
        vx[1][k] = vx[0][k];
        vx[2][k] = vx[0][k];
      end
    end else if (kind == 2) begin
      for (int k = 0; k < 3; k++) vx[2][k] = 2 * vx[1][k] - vx[0][k];
    end else if (kind == 3) begin
      for (int k = 0; k < 3; k++) vx[2][k] = vx[1][k];
    end
    wa = $urandom_range(2000) - 500;
    wb = $urandom_range(2000) - 500;
    wc = $urandom_range(2000) - 500;
    for (int k = 0; k < 3; k++) begin
      q[k] = clip((wa * vx[0][k] + wb * vx[1][k] + wc * vx[2][k]) / 1000
                  + $signed($urandom_range(span)) - span / 2);
      q[3 + k] = clip(vx[0][k]);
      q[6 + k] = clip(vx[1][k]);
      q[9 + k] = clip(vx[2][k]);
    end
  endtask

  initial begin
    coord_t q[12];
    int r;
    cycle_count  = 0;
    hold_request = 1;
    long_hold    = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    out_ch.ready = 1'b0;
    in_ch.point_x  = '0; in_ch.point_y  = '0; in_ch.point_z  = '0;
    in_ch.vert_a_x = '0; in_ch.vert_a_y = '0; in_ch.vert_a_z = '0;
    in_ch.vert_b_x = '0; in_ch.vert_b_y = '0; in_ch.vert_b_z = '0;
    in_ch.vert_c_x = '0; in_ch.vert_c_y = '0; in_ch.vert_c_z = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one query per region of a right triangle with legs of 4.0 in z = 0.
    // Vertex A, B and C, edges AB, AC and BC, then the interior.
    q = '{-4096, -4096, 0,  0, 0, 0,  16384, 0, 0,  0, 16384, 0};
    send_query(q);
    q = '{20480, -100, 50,  0, 0, 0,  16384, 0, 0,  0, 16384, 0};
    send_query(q);
    q = '{-100, 20480, -50,  0, 0, 0,  16384, 0, 0,  0, 16384, 0};
    send_query(q);
    q = '{5000, -4096, 300,  0, 0, 0,  16384, 0, 0,  0, 16384, 0};
    send_query(q);
    q = '{-4096, 7000, -300,  0, 0, 0,  16384, 0, 0,  0, 16384, 0};
    send_query(q);
    q = '{12000, 12000, 999,  0, 0, 0,  16384, 0, 0,  0, 16384, 0};
    send_query(q);
    q = '{3000, 4000, -8000,  0, 0, 0,  16384, 0, 0,  0, 16384, 0};
    send_query(q);
    // Collapsed edge AB, a single-point triangle and collinear vertices.
    q = '{5000, 6000, 7000,  100, 100, 100,  100, 100, 100,  9000, 100, 100};
    send_query(q);
    q = '{5000, -6000, 7000,  300, 300, 300,  300, 300, 300,  300, 300, 300};
    send_query(q);
    q = '{0, 9000, 0,  0, 0, 0,  4096, 0, 0,  8192, 0, 0};
    send_query(q);
    // Field extremes, including saturation on near-degenerate triangles.
    q = '{CMAX, CMAX, CMAX,  CMIN, CMIN, CMIN,  CMAX, CMIN, CMAX,  CMIN, CMAX, CMIN};
    send_query(q);
    q = '{CMIN, CMIN, CMIN,  CMAX, CMAX, CMAX,  CMIN, CMAX, CMIN,  CMAX, CMIN, CMAX};
    send_query(q);
    q = '{CMIN, CMAX, 0,  CMAX, CMIN, 0,  CMIN, CMIN, 1,  CMAX, CMAX, -1};
    send_query(q);
    q = '{0, CMAX, 0,  CMIN, 0, 0,  CMAX, 1, 0,  CMAX, 0, 0};
    send_query(q);
    q = '{-1, -1, -1,  0, 0, 0,  0, 0, 0,  0, 0, 0};
    send_query(q);
    q = '{CMAX, 0, 0,  CMIN, 0, 0,  CMIN, 1, 0,  CMAX, -1, 0};
    send_query(q);
    idle_sender(1);

    // Random part with idling on both sides.
    hold_request = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(99);
      if (r < 15) begin
        for (int k = 0; k < 12; k++) q[k] = any_coord();
      end else if (r < 20) begin
        for (int k = 0; k < 12; k++)
          q[k] = ($urandom_range(1) != 0) ? coord_t'(CMAX) : coord_t'(CMIN);
      end else begin
        shaped_query(q);
      end
      // Mid-run: a long receiver hold while the sender keeps offering.
      if (i == 300) long_hold = 1'b1;
      if (i == 302) long_hold = 1'b0;
      // Later: the sender waits for every awaited result.
      if (i == 700) begin
        idle_sender(1);
        while (awaited_count != 0) @(posedge clk);
      end
      // A stretch with no idling on either side.
      hold_request = (i >= 850 && i < 950) ? 1 : 0;
      send_query(q);
      if (i < 300 || i >= 320) idle_sender((i >= 850 && i < 950) ? 0 : gap_len());
    end
    in_ch.valid <= 1'b0;

    while (awaited_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("closest_point_on_triangle_tb: PASS");
    end else begin
      $display("closest_point_on_triangle_tb: FAIL");
    end
    $finish;
  end
endmodule
